FILE: rtl/core/ffha_pkg.sv
// Shared constants, codes and types of the first-fit heap allocator.
// Used by ffha_use_counter and first_fit_heap_allocator_unit; no dependencies.

package ffha_pkg;

   // Table depth and derived widths
   localparam int MAX_BLOCKS = 64;
   localparam int IDX_W      = $clog2(MAX_BLOCKS);
   localparam int BLK_CNT_W  = $clog2(MAX_BLOCKS + 1);

   // Field widths
   localparam int ADDR_W     = 22;
   localparam int END_W      = 23;
   localparam int HDR_W      = 7;
   localparam int SIZE_W     = 23;
   localparam int USE_W      = 24;
   localparam int STATUS_W   = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 23;

   // Running payload address: base + header + sum of all block strides
   localparam int PAY_W      = SIZE_W + IDX_W + 1;

   localparam int TRAILER_BYTES = 4;

   // Request modes
   localparam logic MODE_ALLOC = 1'b0;
   localparam logic MODE_FREE  = 1'b1;

   // Response status codes
   localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_ZERO    = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_NOMEM   = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_UNKNOWN = 2'd3;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_HEAP_BASE   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HEAP_END    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HEADER_SIZE = 2'd2;

   // Update command for the bytes-in-use counter
   typedef struct packed {
      logic              apply;
      logic              sub;
      logic [USE_W-1:0]  amount;
   } cnt_cmd_type;

endpackage

FILE: rtl/core/first_fit_heap_allocator_unit.sv
// First-fit heap allocator: block table in one synchronous RAM, scanned one entry a cycle.
// An accepted request scans the table entries in order; a hit ends the scan, and a miss
// (append or unknown free) passes through an end state. An empty table skips the scan, and a
// zero-size allocate goes straight to the response. One request at a time: the next request is
// accepted the cycle after the response loads.
// Reset is synchronous: control, block count, top, counter and config return to defaults;
// the table RAM is not cleared, entries at or above the block count are never used.
// Depends on ffha_pkg and ffha_use_counter.

module first_fit_heap_allocator_unit (
   input  logic                            clock,
   input  logic                            reset,
   // request channel
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_mode,
   input  logic [ffha_pkg::SIZE_W-1:0]     req_request_size,
   input  logic [ffha_pkg::ADDR_W-1:0]     req_free_address,
   // response channel
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [ffha_pkg::ADDR_W-1:0]     rsp_address,
   output logic [ffha_pkg::STATUS_W-1:0]   rsp_status,
   output logic [ffha_pkg::USE_W-1:0]      rsp_bytes_in_use,
   // configuration port
   input  logic                            csr_write_enable,
   input  logic [ffha_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [ffha_pkg::CSR_DATA_W-1:0] csr_write_data
);
   import ffha_pkg::*;

   localparam int ENT_W  = SIZE_W + 1;
   localparam int STR_W  = HDR_W + 1;
   localparam int BH_W   = ADDR_W + 1;
   localparam int TOP_W  = SIZE_W + 1;
   localparam int NEED_W = SIZE_W + 2;

   localparam logic [1:0] STATE_IDLE = 2'd0;
   localparam logic [1:0] STATE_SCAN = 2'd1;
   localparam logic [1:0] STATE_END  = 2'd2;
   localparam logic [1:0] STATE_DONE = 2'd3;

   // Configuration registers
   logic [ADDR_W-1:0] heap_base_ff;
   logic [END_W-1:0]  heap_end_ff;
   logic [HDR_W-1:0]  header_size_ff;

   // Control and request registers
   logic [1:0]           state_ff, state_in;
   logic                 mode_ff, mode_in;
   logic [SIZE_W-1:0]    size_ff, size_in;
   logic [ADDR_W-1:0]    faddr_ff, faddr_in;
   logic [HDR_W-1:0]     hdr_ff, hdr_in;
   logic [STR_W-1:0]     stride_ff, stride_in;
   logic [BH_W-1:0]      base_hdr_ff, base_hdr_in;
   logic [PAY_W-1:0]     pay_ff, pay_in;
   logic [BLK_CNT_W-1:0] ev_ff, ev_in;
   logic [BLK_CNT_W-1:0] block_count_ff, block_count_in;
   logic [SIZE_W-1:0]    top_offset_ff, top_offset_in;
   logic [ADDR_W-1:0]    res_addr_ff, res_addr_in;
   logic [STATUS_W-1:0]  res_status_ff, res_status_in;
   cnt_cmd_type          cmd_ff, cmd_in;

   // Response registers
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [ADDR_W-1:0]    rsp_address_ff, rsp_address_in;
   logic [STATUS_W-1:0]  rsp_status_ff, rsp_status_in;
   logic [USE_W-1:0]     rsp_bytes_ff, rsp_bytes_in;

   // Block table RAM: {used, size}
   logic [ENT_W-1:0] table_mem [MAX_BLOCKS];
   logic [ENT_W-1:0] rd_data_ff;
   logic [IDX_W-1:0] rd_addr;
   logic             mem_we;
   logic [IDX_W-1:0] mem_wr_addr;
   logic [ENT_W-1:0] mem_wr_data;

   // Datapath helpers
   logic                 req_fire;
   logic                 slot_free;
   logic                 entry_used;
   logic [SIZE_W-1:0]    entry_size;
   logic                 alloc_hit;
   logic                 free_hit;
   logic [BLK_CNT_W-1:0] ev_next;
   logic [TOP_W-1:0]     top_pay;
   logic [NEED_W-1:0]    need_end;
   logic [USE_W-1:0]     grow;
   logic                 table_full;
   logic                 no_room;
   cnt_cmd_type          cnt_cmd;
   logic [USE_W-1:0]     count_next;

   assign req_stall = (state_ff != STATE_IDLE);
   assign req_fire  = req_valid && !req_stall;
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   assign entry_used = rd_data_ff[SIZE_W];
   assign entry_size = rd_data_ff[SIZE_W-1:0];
   assign alloc_hit  = (mode_ff == MODE_ALLOC) && !entry_used && (entry_size >= size_ff);
   assign free_hit   = (mode_ff == MODE_FREE) && entry_used &&
                       (pay_ff == PAY_W'(faddr_ff));
   assign ev_next    = ev_ff + 1'b1;

   // Append geometry at the heap top
   assign top_pay    = TOP_W'(base_hdr_ff) + TOP_W'(top_offset_ff);
   assign need_end   = NEED_W'(top_pay) + NEED_W'(size_ff);
   assign grow       = USE_W'(size_ff) + USE_W'(hdr_ff) + USE_W'(TRAILER_BYTES);
   assign table_full = (block_count_ff >= BLK_CNT_W'(MAX_BLOCKS));
   assign no_room    = table_full || (need_end >= NEED_W'(heap_end_ff));

   // Read address: entry 0 on accept, the following entry while scanning
   assign rd_addr = (state_ff == STATE_SCAN) ? ev_next[IDX_W-1:0] : '0;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         table_mem[mem_wr_addr] <= mem_wr_data;
      end
      rd_data_ff <= table_mem[rd_addr];
   end

   // Main sequencer
   always_comb begin
      state_in       = state_ff;
      mode_in        = mode_ff;
      size_in        = size_ff;
      faddr_in       = faddr_ff;
      hdr_in         = hdr_ff;
      stride_in      = stride_ff;
      base_hdr_in    = base_hdr_ff;
      pay_in         = pay_ff;
      ev_in          = ev_ff;
      block_count_in = block_count_ff;
      top_offset_in  = top_offset_ff;
      res_addr_in    = res_addr_ff;
      res_status_in  = res_status_ff;
      cmd_in         = cmd_ff;
      mem_we         = 1'b0;
      mem_wr_addr    = ev_ff[IDX_W-1:0];
      mem_wr_data    = {mode_ff == MODE_ALLOC, entry_size};

      unique case (state_ff)
         STATE_IDLE: begin
            if (req_fire) begin
               mode_in       = req_mode;
               size_in       = req_request_size;
               faddr_in      = req_free_address;
               hdr_in        = header_size_ff;
               stride_in     = STR_W'(header_size_ff) + STR_W'(TRAILER_BYTES);
               base_hdr_in   = BH_W'(heap_base_ff) + BH_W'(header_size_ff);
               pay_in        = PAY_W'(heap_base_ff) + PAY_W'(header_size_ff);
               ev_in         = '0;
               res_addr_in   = '0;
               res_status_in = STATUS_OK;
               cmd_in        = '0;
               if ((req_mode == MODE_ALLOC) && (req_request_size == '0)) begin
                  res_status_in = STATUS_ZERO;
                  state_in      = STATE_DONE;
               end else if (block_count_ff == '0) begin
                  state_in = STATE_END;
               end else begin
                  state_in = STATE_SCAN;
               end
            end
         end

         // One table entry per cycle; hit marks the block and ends the scan
         STATE_SCAN: begin
            if (alloc_hit || free_hit) begin
               mem_we        = 1'b1;
               res_status_in = STATUS_OK;
               cmd_in.apply  = 1'b1;
               if (alloc_hit) begin
                  res_addr_in   = pay_ff[ADDR_W-1:0];
                  cmd_in.sub    = 1'b0;
                  cmd_in.amount = USE_W'(size_ff) + USE_W'(hdr_ff);
               end else begin
                  res_addr_in   = faddr_ff;
                  cmd_in.sub    = 1'b1;
                  cmd_in.amount = USE_W'(entry_size) + USE_W'(hdr_ff);
               end
               state_in = STATE_DONE;
            end else if (ev_next == block_count_ff) begin
               state_in = STATE_END;
            end else begin
               ev_in  = ev_next;
               pay_in = pay_ff + PAY_W'(entry_size) + PAY_W'(stride_ff);
            end
         end

         // No match: append for allocate, report unknown for free
         STATE_END: begin
            if (mode_ff == MODE_FREE) begin
               res_status_in = STATUS_UNKNOWN;
               res_addr_in   = '0;
            end else if (no_room) begin
               res_status_in = STATUS_NOMEM;
               res_addr_in   = '0;
            end else begin
               mem_we         = 1'b1;
               mem_wr_addr    = block_count_ff[IDX_W-1:0];
               mem_wr_data    = {1'b1, size_ff};
               block_count_in = block_count_ff + 1'b1;
               top_offset_in  = top_offset_ff + grow[SIZE_W-1:0];
               res_addr_in    = top_pay[ADDR_W-1:0];
               res_status_in  = STATUS_OK;
               cmd_in.apply   = 1'b1;
               cmd_in.sub     = 1'b0;
               cmd_in.amount  = grow;
            end
            state_in = STATE_DONE;
         end

         // Wait for the response register, then update the counter
         STATE_DONE: begin
            if (slot_free) begin
               state_in = STATE_IDLE;
            end
         end

         default: begin
            state_in = STATE_IDLE;
         end
      endcase
   end

   // Counter update goes with the response load
   always_comb begin
      cnt_cmd       = cmd_ff;
      cnt_cmd.apply = cmd_ff.apply && (state_ff == STATE_DONE) && slot_free;
   end

   ffha_use_counter u_use_counter (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cnt_cmd),
      .count_in (count_next)
   );

   // Response register
   always_comb begin
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_address_in = rsp_address_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_bytes_in   = rsp_bytes_ff;
      if ((state_ff == STATE_DONE) && slot_free) begin
         rsp_valid_in   = 1'b1;
         rsp_address_in = res_addr_ff;
         rsp_status_in  = res_status_ff;
         rsp_bytes_in   = count_next;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_address      = rsp_address_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_bytes_in_use = rsp_bytes_ff;

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= STATE_IDLE;
         block_count_ff <= '0;
         top_offset_ff  <= '0;
         cmd_ff         <= '0;
         rsp_valid_ff   <= 1'b0;
         heap_base_ff   <= ADDR_W'(0);
         heap_end_ff    <= END_W'(4063232);
         header_size_ff <= HDR_W'(8);
      end else begin
         state_ff       <= state_in;
         block_count_ff <= block_count_in;
         top_offset_ff  <= top_offset_in;
         cmd_ff         <= cmd_in;
         rsp_valid_ff   <= rsp_valid_in;
         if (csr_write_enable) begin
            if (csr_index == CSR_HEAP_BASE) begin
               heap_base_ff <= csr_write_data[ADDR_W-1:0];
            end
            if (csr_index == CSR_HEAP_END) begin
               heap_end_ff <= csr_write_data[END_W-1:0];
            end
            if (csr_index == CSR_HEADER_SIZE) begin
               header_size_ff <= csr_write_data[HDR_W-1:0];
            end
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      mode_ff        <= mode_in;
      size_ff        <= size_in;
      faddr_ff       <= faddr_in;
      hdr_ff         <= hdr_in;
      stride_ff      <= stride_in;
      base_hdr_ff    <= base_hdr_in;
      pay_ff         <= pay_in;
      ev_ff          <= ev_in;
      res_addr_ff    <= res_addr_in;
      res_status_ff  <= res_status_in;
      rsp_address_ff <= rsp_address_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_bytes_ff   <= rsp_bytes_in;
   end

endmodule

FILE: rtl/core/ffha_use_counter.sv
// Saturating bytes-in-use counter of the heap allocator.
// Depends on ffha_pkg (widths and cnt_cmd_type).

module ffha_use_counter (
   input  logic                       clock,
   input  logic                       reset,
   input  ffha_pkg::cnt_cmd_type      cmd,
   output logic [ffha_pkg::USE_W-1:0] count_in
);
   import ffha_pkg::*;

   logic [USE_W-1:0] count_ff;
   logic [USE_W:0]   sum;

   // Add saturates at all ones, subtract saturates at zero
   assign sum = {1'b0, count_ff} + {1'b0, cmd.amount};

   always_comb begin
      count_in = count_ff;
      if (cmd.apply) begin
         if (cmd.sub) begin
            count_in = (cmd.amount >= count_ff) ? '0 : count_ff - cmd.amount;
         end else begin
            count_in = sum[USE_W] ? '1 : sum[USE_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

endmodule

FILE: dv/first_fit_heap_allocator_unit_tb.sv
// Testbench of first_fit_heap_allocator_unit: directed and random allocate/free requests,
// each response checked against a shadow copy of the block table and counters.
// Depends on ffha_pkg and the allocator RTL; nothing else.

module first_fit_heap_allocator_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import ffha_pkg::*;

   // Register index past the list; writes there are dropped
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;
   localparam logic [END_W-1:0]     HEAP_END_AT_RESET = 23'd4063232;
   localparam logic [HDR_W-1:0]     HEADER_AT_RESET = 7'd8;
   localparam logic [SIZE_W-1:0]    SIZE_TOP = 23'h400000;
   localparam longint               USE_MAX = (64'd1 << USE_W) - 1;
   localparam int                   SETTLE_CYCLES = MAX_BLOCKS + 16;
   localparam int                   CYCLE_LIMIT = 1_500_000;

   typedef struct packed {
      logic [ADDR_W-1:0]   address;
      logic [STATUS_W-1:0] status;
      logic [USE_W-1:0]    in_use;
   } alloc_reply_type;

   // Shadow of the allocator state plus the queue of responses it owes
   class heap_shadow_type;
      logic [ADDR_W-1:0] base_addr;
      logic [END_W-1:0]  end_addr;
      logic [HDR_W-1:0]  hdr_bytes;
      logic [SIZE_W-1:0] blk_size [MAX_BLOCKS];
      bit                blk_used [MAX_BLOCKS];
      int unsigned       blk_count;
      logic [SIZE_W-1:0] top_ofs;
      logic [USE_W-1:0]  bytes_used;
      alloc_reply_type   pending_replies[$];
      int unsigned       errors;

      function new();
         base_addr  = '0;
         end_addr   = HEAP_END_AT_RESET;
         hdr_bytes  = HEADER_AT_RESET;
         blk_count  = 0;
         top_ofs    = '0;
         bytes_used = '0;
         errors     = 0;
      endfunction

      function void set_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_HEAP_BASE:   base_addr = data[ADDR_W-1:0];
            CSR_HEAP_END:    end_addr  = data[END_W-1:0];
            CSR_HEADER_SIZE: hdr_bytes = data[HDR_W-1:0];
            default: ;
         endcase
      endfunction

      // Blocks sit back to back from the base; geometry follows the current registers
      function longint payload_of(int idx);
         longint ofs;
         ofs = longint'(base_addr) + hdr_bytes;
         for (int i = 0; i < idx; i++)
            ofs += longint'(blk_size[i]) + hdr_bytes + TRAILER_BYTES;
         return ofs;
      endfunction

      // Payload address of a random live (or freed) block; random when there is none
      function logic [ADDR_W-1:0] block_address(bit live);
         int cand[$];
         for (int i = 0; i < blk_count; i++)
            if (blk_used[i] == live) cand.push_back(i);
         if (cand.size() == 0) return ADDR_W'($urandom);
         return ADDR_W'(payload_of(cand[$urandom_range(0, cand.size() - 1)]));
      endfunction

      function void bump_count(longint amount);
         longint total;
         total = longint'(bytes_used) + amount;
         bytes_used = (total > USE_MAX) ? USE_W'(USE_MAX) : USE_W'(total);
      endfunction

      function alloc_reply_type predict_reply(logic mode, logic [SIZE_W-1:0] size,
                                              logic [ADDR_W-1:0] faddr);
         alloc_reply_type r;
         longint top_abs;
         longint amount;
         bit hit;
         r = '0;
         r.status = STATUS_OK;
         hit = 1'b0;
         if (mode == MODE_ALLOC) begin
            if (size == '0) begin
               r.status = STATUS_ZERO;
            end else begin
               // first fit over existing blocks, no split
               for (int i = 0; i < blk_count && !hit; i++) begin
                  if (!blk_used[i] && blk_size[i] >= size) begin
                     blk_used[i] = 1'b1;
                     bump_count(longint'(size) + hdr_bytes);
                     r.address = ADDR_W'(payload_of(i));
                     hit = 1'b1;
                  end
               end
               // otherwise append at the top
               if (!hit) begin
                  top_abs = longint'(base_addr) + top_ofs;
                  if (blk_count >= MAX_BLOCKS || top_abs + size + hdr_bytes >= end_addr) begin
                     r.status = STATUS_NOMEM;
                  end else begin
                     blk_size[blk_count] = size;
                     blk_used[blk_count] = 1'b1;
                     blk_count++;
                     r.address = ADDR_W'(top_abs + hdr_bytes);
                     top_ofs = SIZE_W'(longint'(top_ofs) + size + hdr_bytes + TRAILER_BYTES);
                     bump_count(longint'(size) + hdr_bytes + TRAILER_BYTES);
                  end
               end
            end
         end else begin
            for (int i = 0; i < blk_count && !hit; i++) begin
               if (blk_used[i] && payload_of(i) == longint'(faddr)) begin
                  blk_used[i] = 1'b0;
                  amount = longint'(blk_size[i]) + hdr_bytes;
                  // counter floors at zero
                  bytes_used = (amount >= longint'(bytes_used)) ? '0 :
                               USE_W'(longint'(bytes_used) - amount);
                  r.address = faddr;
                  hit = 1'b1;
               end
            end
            if (!hit) r.status = STATUS_UNKNOWN;
         end
         if (r.status != STATUS_OK) r.address = '0;
         r.in_use = bytes_used;
         return r;
      endfunction

      function void note_request(logic mode, logic [SIZE_W-1:0] size,
                                 logic [ADDR_W-1:0] faddr);
         pending_replies.push_back(predict_reply(mode, size, faddr));
      endfunction

      function void check_response(logic [ADDR_W-1:0] address, logic [STATUS_W-1:0] status,
                                   logic [USE_W-1:0] in_use);
         alloc_reply_type want;
         if (pending_replies.size() == 0) begin
            errors++;
            $display("%0t: unexpected response: address %h status %0d bytes_in_use %0d",
                     $time, address, status, in_use);
            return;
         end
         want = pending_replies.pop_front();
         if (address !== want.address) begin
            errors++;
            $display("%0t: address expected %h actual %h", $time, want.address, address);
         end
         if (status !== want.status) begin
            errors++;
            $display("%0t: status expected %0d actual %0d", $time, want.status, status);
         end
         if (in_use !== want.in_use) begin
            errors++;
            $display("%0t: bytes_in_use expected %0d actual %0d", $time, want.in_use, in_use);
         end
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic                  req_mode = MODE_ALLOC;
   logic [SIZE_W-1:0]     req_request_size = '0;
   logic [ADDR_W-1:0]     req_free_address = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [ADDR_W-1:0]     rsp_address;
   logic [STATUS_W-1:0]   rsp_status;
   logic [USE_W-1:0]      rsp_bytes_in_use;
   logic                  csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_HEAP_BASE;
   logic [CSR_DATA_W-1:0] csr_write_data = '0;

   heap_shadow_type shadow = new();
   int              send_idle_pct = 0;
   int              rsp_stall_pct = 0;
   int              cycle_count = 0;

   first_fit_heap_allocator_unit uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_mode         (req_mode),
      .req_request_size (req_request_size),
      .req_free_address (req_free_address),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_address      (rsp_address),
      .rsp_status       (rsp_status),
      .rsp_bytes_in_use (rsp_bytes_in_use),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Response side: check accepted responses, then pick next cycle's stall
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0)
         shadow.check_response(rsp_address, rsp_status, rsp_bytes_in_use);
      rsp_stall <= ($urandom_range(0, 99) < rsp_stall_pct);
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("first_fit_heap_allocator_unit_tb failed");
         $finish;
      end
   end

   // One request, with random idle cycles ahead of it; returns at the accepting edge
   task automatic send_request(logic mode, logic [SIZE_W-1:0] size, logic [ADDR_W-1:0] faddr);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_mode         <= mode;
      req_request_size <= size;
      req_free_address <= faddr;
      do @(posedge clock); while (req_stall !== 1'b0);
      shadow.note_request(mode, size, faddr);
   endtask

   // Hold off requests until every response is back and the block has settled
   task automatic drain_replies();
      req_valid <= 1'b0;
      while (shadow.pending_replies.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write all registers back to back, plus the spare index; block must be idle
   task automatic program_heap(logic [CSR_DATA_W-1:0] base, logic [CSR_DATA_W-1:0] limit,
                               logic [CSR_DATA_W-1:0] hdr);
      logic [CSR_IDX_W-1:0]  idx [4];
      logic [CSR_DATA_W-1:0] val [4];
      idx = '{CSR_HEAP_BASE, CSR_HEAP_END, CSR_HEADER_SIZE, CSR_SPARE};
      val = '{base, limit, hdr, CSR_DATA_W'($urandom)};
      for (int k = 0; k < 4; k++) begin
         csr_write_enable <= 1'b1;
         csr_index        <= idx[k];
         csr_write_data   <= val[k];
         @(posedge clock);
         shadow.set_register(idx[k], val[k]);
      end
      csr_write_enable <= 1'b0;
   endtask

   // Random mix: mostly frees of live blocks and small allocations, some noise
   task automatic run_random(int count);
      logic [SIZE_W-1:0] size;
      logic [ADDR_W-1:0] faddr;
      int pick;
      int shape;
      for (int n = 0; n < count; n++) begin
         pick  = $urandom_range(0, 99);
         shape = $urandom_range(0, 99);
         size  = SIZE_W'($urandom);
         faddr = ADDR_W'($urandom);
         if ($urandom_range(0, 199) == 0) drain_replies();
         if (pick < 48) begin
            if (shape < 4) size = '0;
            else if (shape < 12) size = SIZE_W'($urandom_range(1, SIZE_TOP));
            else if (shape < 60) size = SIZE_W'($urandom_range(1, 64));
            else size = SIZE_W'($urandom_range(1, 600));
            send_request(MODE_ALLOC, size, faddr);
         end else begin
            if (shape < 70) faddr = shadow.block_address(1'b1);
            else if (shape < 82) faddr = shadow.block_address(1'b0);
            send_request(MODE_FREE, size, faddr);
         end
      end
   endtask

   task automatic run_phase(logic [CSR_DATA_W-1:0] base, logic [CSR_DATA_W-1:0] limit,
                            logic [CSR_DATA_W-1:0] hdr, int idle_pct, int stall_pct,
                            int count);
      drain_replies();
      program_heap(base, limit, hdr);
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      run_random(count);
   endtask

   initial begin
      longint heap_limit;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: zero size, unknown free, reuse, counter floor, oversize
      send_request(MODE_ALLOC, '0, '0);
      send_request(MODE_FREE, 23'd5, '0);
      send_request(MODE_ALLOC, 23'd1000, '0);
      send_request(MODE_FREE, '0, ADDR_W'(shadow.payload_of(0)));
      send_request(MODE_ALLOC, 23'd1, '0);
      send_request(MODE_FREE, '0, ADDR_W'(shadow.payload_of(0)));
      send_request(MODE_FREE, '0, ADDR_W'(shadow.payload_of(0)));
      send_request(MODE_ALLOC, SIZE_TOP, 22'h3FFFFF);
      send_request(MODE_ALLOC, SIZE_TOP - 1, '0);
      send_request(MODE_ALLOC, 23'd2000, '0);
      send_request(MODE_ALLOC, 23'd1000, '0);
      send_request(MODE_FREE, 23'h7FFFFF, 22'h3FFFFF);
      send_request(MODE_FREE, '0, 22'h2AAAAA);

      // Heap end placed exactly at the top of the next append
      drain_replies();
      heap_limit = longint'(shadow.base_addr) + shadow.top_ofs + shadow.hdr_bytes + 100;
      program_heap(shadow.base_addr, CSR_DATA_W'(heap_limit), shadow.hdr_bytes);
      send_request(MODE_ALLOC, 23'd100, '0);
      send_request(MODE_ALLOC, 23'd99, '0);
      send_request(MODE_ALLOC, 23'd1, '0);
      send_request(MODE_FREE, '0, ADDR_W'(shadow.payload_of(1)));

      // Random phases across register settings and idle patterns
      run_phase(23'd0, 23'd4194304, 23'd64, 0, 0, 250);
      run_phase(23'h400000 | 23'd1024, 23'd4194304, 23'd1, 64, 0, 250);
      run_phase(23'd4194303, 23'd4194304, 23'd8, 0, 64, 100);
      run_phase(CSR_DATA_W'($urandom_range(0, 65535)), 23'd0,
                CSR_DATA_W'($urandom_range(1, 64)), 12, 12, 250);
      run_phase(23'd0, HEAP_END_AT_RESET, HEADER_AT_RESET, 0, 0, 250);
      run_phase(CSR_DATA_W'($urandom_range(0, 4095)), 23'd4194304,
                CSR_DATA_W'($urandom_range(1, 64)), 64, 0, 250);
      run_phase(CSR_DATA_W'($urandom_range(0, 4095)), 23'd4194304,
                CSR_DATA_W'($urandom_range(1, 64)), 0, 64, 250);
      run_phase(23'd0, 23'd4194304, 23'd1, 12, 12, 250);

      drain_replies();
      if (shadow.errors == 0)
         $display("first_fit_heap_allocator_unit_tb passed");
      else
         $display("first_fit_heap_allocator_unit_tb failed");
      $finish;
   end

endmodule
